[sv/sob_pkg.sv]
// ----------------------------------------------------------------------------
// sob_pkg - shared types and constants of the 3x3 Sobel gradient block
// Pixel and column types, frame limits, register indexes and the gradient
// kernel used by the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package sob_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int GRAD_W     = 11;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top, middle and bottom row pixels
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef logic signed [GRAD_W-1:0] grad_t;

  function automatic grad_t pix_ext(input pix_t p);
    return grad_t'({3'b000, p});
  endfunction

  // Horizontal gradient: right column minus left column, middle row doubled
  function automatic grad_t sobel_gx(input col_t l, input col_t r);
    grad_t dt, dm, db;
    dt = pix_ext(r.top) - pix_ext(l.top);
    dm = pix_ext(r.mid) - pix_ext(l.mid);
    db = pix_ext(r.bot) - pix_ext(l.bot);
    return dt + (dm <<< 1) + db;
  endfunction

  // Vertical gradient: bottom row minus top row, centre column doubled
  function automatic grad_t sobel_gy(input col_t l, input col_t c, input col_t r);
    grad_t dl, dc, dr;
    dl = pix_ext(l.bot) - pix_ext(l.top);
    dc = pix_ext(c.bot) - pix_ext(c.top);
    dr = pix_ext(r.bot) - pix_ext(r.top);
    return dl + (dc <<< 1) + dr;
  endfunction

endpackage

`default_nettype wire

[sv/sob_line_ram.sv]
// ----------------------------------------------------------------------------
// sob_line_ram - one line store of the Sobel block
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_line_ram
  import sob_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [COL_W-1:0] waddr,
  input  wire pix_t             wdata,
  input  wire logic             re,
  input  wire logic [COL_W-1:0] raddr,
  output pix_t                  rdata
);

  pix_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data unless a new read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/sob_col_cell.sv]
// ----------------------------------------------------------------------------
// sob_col_cell - one column cell of the 3x3 window
// Holds three pixels of one column; on shift, take the neighbor's column.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_col_cell
  import sob_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire col_t col_in,
  output col_t      col
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

endmodule

`default_nettype wire

[sv/sobel_gradient_3x3.sv]
// ----------------------------------------------------------------------------
// sobel_gradient_3x3 - streaming 3x3 Sobel gradient
// Raster pixels in, one gx/gy result per interior window centre out.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  pixel    | in        | pixel_valid / pixel_stall | pixel
//  grad     | out       | grad_valid / grad_stall   | grad_x grad_y centre_col
//           |           |                           | centre_row frame_last
//  config   | in        | cfg_write_en              | cfg_index cfg_data
//
// One pixel per clock sustained while the pipeline is not stalled; a request
// passes the line store read, window shift and output register in that order.
// The pipeline collapses bubbles, so up to two requests stay buffered while
// the output is stalled before pixel_stall rises.
// Reset clears counters, pipeline valids and the window, and loads 640x480.
// A config write to the width or height register restarts the frame at row 0,
// column 0; the line stores keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_3x3
  import sob_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // pixel stream
  input  wire logic                  pixel_valid,
  output logic                       pixel_stall,
  input  wire logic [PIX_W-1:0]      pixel,
  // gradient stream
  output logic                       grad_valid,
  input  wire logic                  grad_stall,
  output logic signed [GRAD_W-1:0]   grad_x,
  output logic signed [GRAD_W-1:0]   grad_y,
  output logic [COL_W-1:0]           centre_col,
  output logic [ROW_W-1:0]           centre_row,
  output logic                       frame_last
);

  // --------------------------------------------------------------------------
  // Configuration and frame geometry
  // --------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic [COL_W-1:0]    last_col;
  logic [ROW_W-1:0]    last_row;
  logic                cfg_hit;

  assign cfg_hit = cfg_write_en &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width into 3..MAX_WIDTH and raise height to at least 3
  always_comb begin
    priority if (image_width < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = image_width;
    end
    height_eff = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
  end

  assign last_col = COL_W'(width_eff - WIDTH_W'(1));
  assign last_row = height_eff - HEIGHT_W'(1);

  // --------------------------------------------------------------------------
  // Pipeline control: each stage advances when the next one is empty or moving
  // --------------------------------------------------------------------------
  logic s1_valid, s1_adv;
  logic s2_valid, s2_adv;
  logic in_fire;

  assign s2_adv      = s2_valid && (!grad_valid || !grad_stall);
  assign s1_adv      = s1_valid && (!s2_valid || s2_adv);
  assign pixel_stall = s1_valid && !s1_adv;
  assign in_fire     = pixel_valid && !pixel_stall;

  // --------------------------------------------------------------------------
  // Position counters: wrap at end of row and end of frame
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_count, col_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             at_last_col, at_last_row;

  assign at_last_col = (col_count == last_col);
  assign at_last_row = (row_count == last_row);

  always_comb begin
    col_count_next = col_count + COL_W'(1);
    row_count_next = row_count;
    if (at_last_col) begin
      col_count_next = '0;
      row_count_next = at_last_row ? '0 : row_count + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: request taken, line stores read at its column
  // --------------------------------------------------------------------------
  pix_t             s1_px;
  logic [COL_W-1:0] s1_addr;
  logic             s1_emit;
  logic             s1_last;
  logic [COL_W-1:0] s1_ccol;
  logic [ROW_W-1:0] s1_crow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px   <= pixel;
      s1_addr <= col_count;
      // only interior centres produce a result
      s1_emit <= (col_count >= COL_W'(2)) && (row_count >= ROW_W'(2));
      s1_last <= at_last_col && at_last_row;
      s1_ccol <= col_count - COL_W'(1);
      s1_crow <= row_count - ROW_W'(1);
    end
  end

  pix_t up_rd, mid_rd;

  // Upper store takes the old middle row; middle store takes the new pixel
  sob_line_ram u_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (mid_rd),
    .re    (in_fire),
    .raddr (col_count),
    .rdata (up_rd)
  );

  sob_line_ram u_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (s1_px),
    .re    (in_fire),
    .raddr (col_count),
    .rdata (mid_rd)
  );

  // --------------------------------------------------------------------------
  // Stage 2: window of three column cells, shifting right to left
  // --------------------------------------------------------------------------
  col_t new_col;
  col_t win [3];
  col_t win_in [3];

  assign new_col = '{top: up_rd, mid: mid_rd, bot: s1_px};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    if (i == 2) begin : g_head
      assign win_in[i] = new_col;
    end else begin : g_link
      assign win_in[i] = win[i+1];
    end
    sob_col_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_adv),
      .col_in (win_in[i]),
      .col    (win[i])
    );
  end

  logic             s2_last;
  logic [COL_W-1:0] s2_ccol;
  logic [ROW_W-1:0] s2_crow;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_emit;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_last <= s1_last;
      s2_ccol <= s1_ccol;
      s2_crow <= s1_crow;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: gradients from the held window
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (s2_adv) begin
      grad_valid <= 1'b1;
    end else if (!grad_stall) begin
      grad_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      grad_x     <= sobel_gx(win[0], win[2]);
      grad_y     <= sobel_gy(win[0], win[1], win[2]);
      centre_col <= s2_ccol;
      centre_row <= s2_crow;
      frame_last <= s2_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Line store write never lands on the column being read
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    s1_adv && in_fire |-> s1_addr != col_count)
    else $error("line store read and write hit the same column");

  // A held window result is never shifted away
  a_window_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_adv |-> !s1_adv)
    else $error("window shifted under a pending result");

  // Input stalls only when stage 1 is really blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid && s2_valid && grad_valid && grad_stall)
    else $error("pixel_stall without a full, stalled pipeline");

  // Results never sit on the left or top border
  a_interior: assert property (@(posedge clk) disable iff (rst)
    grad_valid |-> centre_col != '0 && centre_row != '0)
    else $error("result for a border centre");

endmodule

`default_nettype wire
